FILE: src/hc3_pkg.sv
// Package with the payload types, control structs and modulo-26 helpers of the Hill cipher unit.
`timescale 1ns / 1ps

package hc3_pkg;

  localparam int unsigned KEY_W  = 45;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned ADDR_W = 3;
  localparam logic [ADDR_W-1:0] KEY_ADDR = '0;
  localparam logic [4:0] MODULUS = 5'd26;

  typedef struct packed {
    logic       mode;
    logic [4:0] letter;
    logic       end_of_text;
  } in_data_t;

  typedef struct packed {
    logic [4:0] out_letter;
    logic       last;
    logic       status;
  } out_data_t;

  typedef struct packed {
    logic accept;
    logic adj_en;
    logic det_en;
    logic scale_en;
    logic out_load;
    logic last_row;
  } hc3_cmd_t;

  typedef struct packed {
    logic blk_close;
  } hc3_sts_t;

  function automatic logic [4:0] red26(input logic [4:0] x);
    return (x >= MODULUS) ? (x - MODULUS) : x;
  endfunction

  // Remainder of an 11-bit value by 26 through a reciprocal multiply and one correction.
  function automatic logic [4:0] mod26_11(input logic [10:0] x);
    logic [17:0] t;
    logic [6:0]  q;
    logic [10:0] r;
    t = 18'(x) * 18'd78;
    q = t[17:11];
    r = x - (11'(q) * 11'd26);
    if (r >= 11'd26) begin
      r = r - 11'd26;
    end
    return r[4:0];
  endfunction

  function automatic logic [4:0] prod26(input logic [4:0] a, input logic [4:0] b);
    logic [9:0] p;
    p = a * b;
    return mod26_11({1'b0, p});
  endfunction

  function automatic logic [4:0] sub26(input logic [4:0] a, input logic [4:0] b);
    return (a >= b) ? (a - b) : (a + MODULUS - b);
  endfunction

  function automatic logic [4:0] inv26(input logic [4:0] d);
    logic [4:0] r;
    case (d)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: src/hc3_ctrl.sv
// Controller state machine that sequences letter transfers, key inversion and result output.
`timescale 1ns / 1ps

module hc3_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  hc3_pkg::hc3_sts_t sts,
  output hc3_pkg::hc3_cmd_t cmd
);
  import hc3_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADJ,
    S_DET,
    S_SCALE,
    S_OUT
  } state_t;

  state_t     state_r;
  logic       out_valid_r;
  logic [1:0] row_r;
  logic       out_free;

  always_comb begin
    in_ready     = (state_r == S_IDLE);
    out_free     = !out_valid_r || out_ready;
    cmd.accept   = in_valid && in_ready;
    cmd.adj_en   = (state_r == S_ADJ);
    cmd.det_en   = (state_r == S_DET);
    cmd.scale_en = (state_r == S_SCALE);
    cmd.out_load = (state_r == S_OUT) && out_free;
    cmd.last_row = (row_r == 2'd2);
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      row_r       <= 2'd0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (cmd.accept && sts.blk_close) begin
            state_r <= S_ADJ;
          end
        end
        S_ADJ: begin
          state_r <= S_DET;
        end
        S_DET: begin
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          state_r <= S_OUT;
          row_r   <= 2'd0;
        end
        S_OUT: begin
          if (cmd.out_load) begin
            row_r <= row_r + 2'd1;
            if (cmd.last_row) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_close_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && sts.blk_close |=> state_r == S_ADJ)
    else $error("block close did not start key processing");

  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ADJ |=> state_r == S_DET ##1 state_r == S_SCALE ##1 state_r == S_OUT)
    else $error("key processing sequence broken");

  a_third_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load && cmd.last_row |=> state_r == S_IDLE && out_valid_r)
    else $error("third result did not return the controller to idle");

endmodule

FILE: src/hc3_datapath.sv
// Datapath with the key register, letter buffer, inverse-key arithmetic and result register.
`timescale 1ns / 1ps

module hc3_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hc3_pkg::in_data_t           in_data,
  output hc3_pkg::out_data_t          out_data,
  input  hc3_pkg::hc3_cmd_t           cmd,
  output hc3_pkg::hc3_sts_t           sts,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hc3_pkg::ADDR_W-1:0]  paddr,
  input  logic [hc3_pkg::DATA_W-1:0]  pwdata,
  output logic [hc3_pkg::DATA_W-1:0]  prdata
);
  import hc3_pkg::*;

  logic [KEY_W-1:0] key_r;
  logic [4:0]       held_r [2];
  logic [1:0]       fill_cnt_r;
  logic [4:0]       p_r [3];
  logic             mode_r;
  logic             eot_r;
  logic [4:0]       madj_r [9];
  logic [4:0]       m_r [9];
  logic [4:0]       dinv_r;
  logic             status_r;
  out_data_t        out_data_r;

  logic [4:0]  kr [9];
  logic [4:0]  madj [9];
  logic [4:0]  let_red;
  logic [1:0]  cnt;
  logic [10:0] det_sum;
  logic [4:0]  dinv;
  logic [10:0] acc;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      kr[i] = red26(key_r[5*i +: 5]);
    end
    madj[0] = sub26(prod26(kr[4], kr[8]), prod26(kr[7], kr[5]));
    madj[3] = sub26(prod26(kr[5], kr[6]), prod26(kr[3], kr[8]));
    madj[6] = sub26(prod26(kr[3], kr[7]), prod26(kr[6], kr[4]));
    madj[1] = sub26(prod26(kr[2], kr[7]), prod26(kr[1], kr[8]));
    madj[4] = sub26(prod26(kr[0], kr[8]), prod26(kr[2], kr[6]));
    madj[7] = sub26(prod26(kr[6], kr[1]), prod26(kr[0], kr[7]));
    madj[2] = sub26(prod26(kr[1], kr[5]), prod26(kr[2], kr[4]));
    madj[5] = sub26(prod26(kr[3], kr[2]), prod26(kr[0], kr[5]));
    madj[8] = sub26(prod26(kr[0], kr[4]), prod26(kr[3], kr[1]));
    det_sum = 11'(kr[0] * madj_r[0]) + 11'(kr[1] * madj_r[3]) + 11'(kr[2] * madj_r[6]);
    dinv    = inv26(mod26_11(det_sum));
    acc     = 11'(m_r[0] * p_r[0]) + 11'(m_r[1] * p_r[1]) + 11'(m_r[2] * p_r[2]);
    let_red = red26(in_data.letter);
    cnt     = (fill_cnt_r == 2'd3) ? 2'd2 : fill_cnt_r;
    sts.blk_close = (cnt == 2'd2) || in_data.end_of_text;
  end

  always_comb begin
    prdata = '0;
    if (paddr == KEY_ADDR) begin
      prdata = DATA_W'(key_r);
    end
  end

  assign out_data = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r      <= '0;
      held_r[0]  <= '0;
      held_r[1]  <= '0;
      fill_cnt_r <= 2'd0;
    end else begin
      if (psel && penable && pwrite && paddr == KEY_ADDR) begin
        key_r <= pwdata[KEY_W-1:0];
      end
      if (cmd.accept) begin
        if (sts.blk_close) begin
          held_r[0]  <= '0;
          held_r[1]  <= '0;
          fill_cnt_r <= 2'd0;
        end else begin
          held_r[cnt[0]] <= let_red;
          fill_cnt_r     <= cnt + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && sts.blk_close) begin
      p_r[0] <= (cnt == 2'd0) ? let_red : held_r[0];
      p_r[1] <= (cnt == 2'd1) ? let_red : held_r[1];
      p_r[2] <= (cnt == 2'd2) ? let_red : 5'd0;
      mode_r <= in_data.mode;
      eot_r  <= in_data.end_of_text;
    end
    if (cmd.adj_en) begin
      madj_r <= madj;
    end
    if (cmd.det_en) begin
      dinv_r   <= dinv;
      status_r <= mode_r && (dinv == 5'd0);
    end
    if (cmd.scale_en) begin
      for (int i = 0; i < 9; i++) begin
        m_r[i] <= mode_r ? prod26(madj_r[i], dinv_r) : kr[i];
      end
    end else if (cmd.out_load) begin
      for (int i = 0; i < 6; i++) begin
        m_r[i] <= m_r[i+3];
      end
    end
    if (cmd.out_load) begin
      out_data_r.out_letter <= status_r ? 5'd0 : mod26_11(acc);
      out_data_r.last       <= eot_r && cmd.last_row;
      out_data_r.status     <= status_r;
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_cnt_r != 2'd3)
    else $error("letter buffer count out of range");

  a_close_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && sts.blk_close |=> fill_cnt_r == 2'd0 && held_r[1] == 5'd0)
    else $error("letter buffer not emptied at block close");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.out_load) && out_data_r.status |-> out_data_r.out_letter == 5'd0)
    else $error("result letter not zero under bad key status");

endmodule

FILE: src/hill_cipher_3x3_mod26_unit.sv
// Top level of the 3x3 Hill cipher unit working modulo 26.
`timescale 1ns / 1ps

// Letters enter on the in_ channel (valid/ready), one per transfer, as mode,
// letter and end_of_text. Letters are held until a block of three is complete
// or end_of_text closes it early with zero padding. Each closed block yields
// three results on the out_ channel: out_letter, last and status.
// A letter that does not close a block is stored in the letter buffer. A closing
// transfer starts the key pass through the adjugate, determinant and inverse, and
// scaling states, and the first result is then loaded into the output register.
// The three results follow on consecutive cycles while out_ready is high; the
// input accepts the next letter once the third result has been loaded into
// the output register. A stalled receiver holds the output register and the row
// sequencer; the input stays closed until the block's results are loaded.
// The key must be written through the APB port at address 0 while the block is
// idle; the block itself does not enforce this.
// Reset clears the key, the letter buffer and all control state.
module hill_cipher_3x3_mod26_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  hc3_pkg::in_data_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output hc3_pkg::out_data_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hc3_pkg::ADDR_W-1:0]  paddr,
  input  logic [hc3_pkg::DATA_W-1:0]  pwdata,
  output logic [hc3_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import hc3_pkg::*;

  hc3_cmd_t cmd;
  hc3_sts_t sts;

  assign pready = 1'b1;

  hc3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hc3_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_data (out_data),
    .cmd      (cmd),
    .sts      (sts),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
  );

endmodule
